### rtl/tkk_pkg.sv
// Shared types and constants for the top-k keypoint selector.
package tkk_pkg;

	localparam int COORD_W = 32;
	localparam int SCORE_W = 32;
	localparam int LIMIT_W = 7;
	localparam int RANK_W  = 6;
	localparam int COUNT_W = 7;

	localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd64;

	// input queue between front and back; depth is a power of two
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = 1;
	localparam int QUEUE_CW    = 2;

	// one queued keypoint request
	typedef struct packed {
		logic [COORD_W-1:0] x_bits;
		logic [COORD_W-1:0] y_bits;
		logic [SCORE_W-1:0] strength;
		logic               last;
	} tkk_item_t;

	// one entry of the ranked store
	typedef struct packed {
		logic [SCORE_W-1:0] strength;
		logic [COORD_W-1:0] x_bits;
		logic [COORD_W-1:0] y_bits;
	} tkk_entry_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_CHECK,
		BK_SCAN,
		BK_PUT,
		BK_DONE,
		BK_EMIT_RD,
		BK_EMIT_WR,
		BK_EMPTY
	} tkk_back_state_t;

endpackage

### rtl/tkk_front.sv
// Front end: takes keypoint requests, tags the frame end and queues them for the back end.
module tkk_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [tkk_pkg::COORD_W-1:0] point_x_bits,
	input  logic [tkk_pkg::COORD_W-1:0] point_y_bits,
	input  logic [tkk_pkg::SCORE_W-1:0] strength,
	input  logic                       frame_end,
	output logic                       q_valid,
	input  logic                       q_ready,
	output tkk_pkg::tkk_item_t         q_item
);
	import tkk_pkg::*;

	tkk_item_t            slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wr_ptr_q;
	logic [QUEUE_AW-1:0]  rd_ptr_q;
	logic [QUEUE_CW-1:0]  cnt_q;
	logic                 push;
	logic                 pop;
	tkk_item_t            in_item;

	// classify and pack the incoming request
	always_comb begin
		in_item.x_bits   = point_x_bits;
		in_item.y_bits   = point_y_bits;
		in_item.strength = strength;
		in_item.last     = frame_end;
	end

	assign in_ready = (cnt_q != QUEUE_CW'(QUEUE_DEPTH));
	assign q_valid  = (cnt_q != '0);
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;
	assign q_item   = slot_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QUEUE_CW'(1);
				2'b01:   cnt_q <= cnt_q - QUEUE_CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QUEUE_CW'(QUEUE_DEPTH))
		else $error("queue count past depth");
	a_push_only: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + QUEUE_CW'(1))
		else $error("queue count missed a push");
	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - QUEUE_CW'(1))
		else $error("queue count missed a pop");
`endif

endmodule

### rtl/tkk_back.sv
// Back end: ranked store with insertion sequencer and frame-end emission.
module tkk_back #(
	parameter int KEEP_DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [tkk_pkg::LIMIT_W-1:0] keep_limit,
	input  logic                        q_valid,
	output logic                        q_ready,
	input  tkk_pkg::tkk_item_t          q_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tkk_pkg::COORD_W-1:0] out_x_bits,
	output logic [tkk_pkg::COORD_W-1:0] out_y_bits,
	output logic [tkk_pkg::SCORE_W-1:0] out_strength,
	output logic [tkk_pkg::RANK_W-1:0]  rank,
	output logic [tkk_pkg::COUNT_W-1:0] kept_count,
	output logic                        empty_res,
	output logic                        run_end
);
	import tkk_pkg::*;

	localparam int AW = (KEEP_DEPTH > 1) ? $clog2(KEEP_DEPTH) : 1;
	localparam int CW = $clog2(KEEP_DEPTH + 1);
	localparam int XW = (CW > LIMIT_W) ? CW : LIMIT_W;

	tkk_entry_t       mem [KEEP_DEPTH];
	tkk_entry_t       rd_data_q;
	tkk_item_t        cur_q;
	tkk_back_state_t  state_q, state_d;
	logic [CW-1:0]    fill_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    k_q;
	logic [CW-1:0]    n_q;
	logic             out_valid_q;

	logic [XW-1:0]    limit_ext;
	logic [CW-1:0]    lim;
	logic [CW-1:0]    fill_eff;
	logic             has_room;
	logic             lim_zero;
	logic [CW-1:0]    fill_m1;
	logic [CW-1:0]    lim_m1;
	logic [CW-1:0]    idx_m1;
	logic [CW-1:0]    idx_m2;
	logic             stop_here;
	logic             out_free;
	logic             last_emit;

	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	tkk_entry_t       wr_data;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic             out_load;
	logic             emit_empty;
	tkk_entry_t       cur_entry;
	tkk_entry_t       head_entry;

	// active limit and fill level cut to it
	assign limit_ext = XW'(keep_limit);
	assign lim       = (limit_ext > XW'(KEEP_DEPTH)) ? CW'(KEEP_DEPTH) : CW'(limit_ext);
	assign fill_eff  = (fill_q > lim) ? lim : fill_q;
	assign has_room  = (fill_eff < lim);
	assign lim_zero  = (lim == '0);
	assign fill_m1   = fill_eff - CW'(1);
	assign lim_m1    = lim - CW'(1);
	assign idx_m1    = idx_q - CW'(1);
	assign idx_m2    = idx_q - CW'(2);

	// stored entry ranks at or ahead of the new one: stable order
	assign stop_here = (rd_data_q.strength >= cur_q.strength);
	assign out_free  = !out_valid_q || out_ready;
	assign last_emit = ((k_q + CW'(1)) == n_q);

	assign cur_entry  = '{strength: cur_q.strength, x_bits: cur_q.x_bits, y_bits: cur_q.y_bits};
	assign head_entry = '{strength: q_item.strength, x_bits: q_item.x_bits,
		y_bits: q_item.y_bits};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					priority if (lim_zero)         state_d = BK_DONE;
					else if (!has_room)            state_d = BK_CHECK;
					else if (fill_eff == '0)       state_d = BK_DONE;
					else                           state_d = BK_SCAN;
				end
			end
			BK_CHECK: begin
				priority if (stop_here)        state_d = BK_DONE;
				else if (idx_q == '0)          state_d = BK_PUT;
				else                           state_d = BK_SCAN;
			end
			BK_SCAN: begin
				priority if (stop_here)        state_d = BK_DONE;
				else if (idx_q == CW'(1))      state_d = BK_PUT;
				else                           state_d = BK_SCAN;
			end
			BK_PUT:     state_d = BK_DONE;
			BK_DONE: begin
				priority if (!cur_q.last)      state_d = BK_IDLE;
				else if (fill_q == '0)         state_d = BK_EMPTY;
				else                           state_d = BK_EMIT_RD;
			end
			BK_EMIT_RD: state_d = BK_EMIT_WR;
			BK_EMIT_WR: begin
				if (out_free) begin
					state_d = last_emit ? BK_IDLE : BK_EMIT_RD;
				end
			end
			BK_EMPTY: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default:    state_d = BK_IDLE;
		endcase
	end

	// sequencer outputs: store ports, queue pop, output load
	always_comb begin
		q_ready    = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = '0;
		wr_data    = cur_entry;
		rd_en      = 1'b0;
		rd_addr    = '0;
		out_load   = 1'b0;
		emit_empty = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				q_ready = q_valid;
				if (q_valid && !lim_zero) begin
					priority if (!has_room) begin
						rd_en   = 1'b1;
						rd_addr = lim_m1[AW-1:0];
					end else if (fill_eff == '0) begin
						wr_en   = 1'b1;
						wr_data = head_entry;
					end else begin
						rd_en   = 1'b1;
						rd_addr = fill_m1[AW-1:0];
					end
				end
			end
			BK_CHECK: begin
				if (!stop_here && idx_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = idx_m1[AW-1:0];
				end
			end
			BK_SCAN: begin
				wr_en   = 1'b1;
				wr_addr = idx_q[AW-1:0];
				if (!stop_here) begin
					wr_data = rd_data_q;
					if (idx_q != CW'(1)) begin
						rd_en   = 1'b1;
						rd_addr = idx_m2[AW-1:0];
					end
				end
			end
			BK_PUT: begin
				wr_en   = 1'b1;
				wr_addr = idx_q[AW-1:0];
			end
			BK_DONE: begin
			end
			BK_EMIT_RD: begin
				rd_en   = 1'b1;
				rd_addr = k_q[AW-1:0];
			end
			BK_EMIT_WR: begin
				out_load = out_free;
			end
			BK_EMPTY: begin
				out_load   = out_free;
				emit_empty = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// ranked store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// current request
	always_ff @(posedge clk) begin
		if (q_ready) begin
			cur_q <= q_item;
		end
	end

	// sequencer state, counters and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			fill_q  <= '0;
			idx_q   <= '0;
			k_q     <= '0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			if (q_ready) begin
				idx_q  <= has_room ? fill_eff : lim_m1;
				fill_q <= has_room ? (fill_eff + CW'(1)) : fill_eff;
			end
			if (state_q == BK_SCAN && !stop_here) begin
				idx_q <= idx_m1;
			end
			if (state_q == BK_DONE && cur_q.last) begin
				n_q    <= fill_q;
				k_q    <= '0;
				fill_q <= '0;
			end
			if (out_load && !emit_empty) begin
				k_q <= k_q + CW'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (emit_empty) begin
				out_x_bits   <= '0;
				out_y_bits   <= '0;
				out_strength <= '0;
				rank         <= '0;
				kept_count   <= '0;
				empty_res    <= 1'b1;
				run_end      <= 1'b1;
			end else begin
				out_x_bits   <= rd_data_q.x_bits;
				out_y_bits   <= rd_data_q.y_bits;
				out_strength <= rd_data_q.strength;
				rank         <= RANK_W'(k_q);
				kept_count   <= COUNT_W'(n_q);
				empty_res    <= 1'b0;
				run_end      <= last_emit;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(KEEP_DEPTH))
		else $error("fill level past store depth");
	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SCAN) |-> (idx_q != '0))
		else $error("shift pass at slot zero");
	a_run_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (emit_empty || last_emit)) |=> (state_q == BK_IDLE))
		else $error("sequencer not idle after final result");
`endif

endmodule

### rtl/top_k_keypoint_selector.sv
// Top level: stable top-k keypoint selector with limit register, front queue and back end.
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------------
//  in      | in_valid/in_ready  | point_x_bits, point_y_bits, strength, frame_end
//  out     | out_valid/out_ready| out_x_bits, out_y_bits, out_strength, rank,
//          |                    | kept_count, empty_res, run_end
//  cfg     | cfg_wr_en          | cfg_wr_data (keep_limit)
//
// In the back end a request into an empty store is written at once; otherwise the
// sequencer reads from the tail and moves each lower-ranked stored entry down a slot,
// as the ranked store does one read and one write per cycle.
// On the frame end each kept keypoint is read from the store, then loaded for output.
// A two-entry queue lets requests arrive while the back end is busy.
// Reset clears control state only; the store needs no clearing pass.
module top_k_keypoint_selector #(
	parameter int KEEP_DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [tkk_pkg::LIMIT_W-1:0] cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tkk_pkg::COORD_W-1:0] point_x_bits,
	input  logic [tkk_pkg::COORD_W-1:0] point_y_bits,
	input  logic [tkk_pkg::SCORE_W-1:0] strength,
	input  logic                        frame_end,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tkk_pkg::COORD_W-1:0] out_x_bits,
	output logic [tkk_pkg::COORD_W-1:0] out_y_bits,
	output logic [tkk_pkg::SCORE_W-1:0] out_strength,
	output logic [tkk_pkg::RANK_W-1:0]  rank,
	output logic [tkk_pkg::COUNT_W-1:0] kept_count,
	output logic                        empty_res,
	output logic                        run_end
);
	import tkk_pkg::*;

	logic [LIMIT_W-1:0] keep_limit_q;
	logic               q_valid;
	logic               q_ready;
	tkk_item_t          q_item;

	// keep_limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_limit_q <= LIMIT_RST;
		end else if (cfg_wr_en) begin
			keep_limit_q <= cfg_wr_data;
		end
	end

	tkk_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.point_x_bits (point_x_bits),
		.point_y_bits (point_y_bits),
		.strength     (strength),
		.frame_end    (frame_end),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_item       (q_item)
	);

	tkk_back #(
		.KEEP_DEPTH (KEEP_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.keep_limit   (keep_limit_q),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_item       (q_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_x_bits   (out_x_bits),
		.out_y_bits   (out_y_bits),
		.out_strength (out_strength),
		.rank         (rank),
		.kept_count   (kept_count),
		.empty_res    (empty_res),
		.run_end      (run_end)
	);

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the top-k keypoint selector: queued driver, monitor and ranking model.
module testbench;

	import tkk_pkg::*;

	localparam int          DEPTH         = 64;
	// back end may still be working on up to three requests after the last result
	localparam int          SETTLE_CYCLES = 3 * (DEPTH + 3) + 64;
	localparam int unsigned CYCLE_LIMIT   = 400000;

	typedef enum logic [1:0] {
		STEP_POINT,
		STEP_LIMIT,
		STEP_PACE,
		STEP_DRAIN
	} step_kind_e;

	typedef enum logic [1:0] {
		PACE_RX_SLOW,
		PACE_TX_SLOW,
		PACE_FREE
	} pace_e;

	typedef struct packed {
		step_kind_e         kind;
		logic [COORD_W-1:0] x_bits;
		logic [COORD_W-1:0] y_bits;
		logic [SCORE_W-1:0] strength;
		logic               last;
		logic [LIMIT_W-1:0] limit;
		pace_e              pace;
	} step_t;

	typedef struct packed {
		logic [COORD_W-1:0] x_bits;
		logic [COORD_W-1:0] y_bits;
		logic [SCORE_W-1:0] strength;
		logic [RANK_W-1:0]  rank;
		logic [COUNT_W-1:0] count;
		logic               empty;
		logic               run_end;
	} ranked_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               cfg_wr_en    = 1'b0;
	logic [LIMIT_W-1:0] cfg_wr_data  = '0;
	logic               in_valid     = 1'b0;
	logic               in_ready;
	logic [COORD_W-1:0] point_x_bits = '0;
	logic [COORD_W-1:0] point_y_bits = '0;
	logic [SCORE_W-1:0] strength     = '0;
	logic               frame_end    = 1'b0;
	logic               out_valid;
	logic               out_ready    = 1'b0;
	logic [COORD_W-1:0] out_x_bits;
	logic [COORD_W-1:0] out_y_bits;
	logic [SCORE_W-1:0] out_strength;
	logic [RANK_W-1:0]  rank;
	logic [COUNT_W-1:0] kept_count;
	logic               empty_res;
	logic               run_end;

	// stimulus and expectations
	step_t       pending[$];
	ranked_t     ranked_due[$];
	pace_e       pace = PACE_RX_SLOW;
	int unsigned fails;
	int unsigned cycle_count;

	// model of the ranked store
	logic [SCORE_W-1:0] model_score [0:DEPTH-1];
	logic [COORD_W-1:0] model_x     [0:DEPTH-1];
	logic [COORD_W-1:0] model_y     [0:DEPTH-1];
	int unsigned        model_fill;
	logic [LIMIT_W-1:0] model_limit = LIMIT_RST;

	// driver scratch
	logic        drv_fire;
	logic        drv_valid;
	logic        drv_wr;
	step_t       drv_head;
	int unsigned settle;
	int unsigned tx_calm;
	int unsigned rx_calm;

	top_k_keypoint_selector #(
		.KEEP_DEPTH(DEPTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.point_x_bits(point_x_bits),
		.point_y_bits(point_y_bits),
		.strength    (strength),
		.frame_end   (frame_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_x_bits  (out_x_bits),
		.out_y_bits  (out_y_bits),
		.out_strength(out_strength),
		.rank        (rank),
		.kept_count  (kept_count),
		.empty_res   (empty_res),
		.run_end     (run_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// limit above the store depth behaves as the depth
	function automatic int unsigned cap_limit();
		return (model_limit > DEPTH) ? DEPTH : model_limit;
	endfunction

	// rank one keypoint into the model; on frame end queue the ranked list
	function automatic void rank_keypoint(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [SCORE_W-1:0] s, input logic last);
		int unsigned lim;
		int unsigned pos;
		int unsigned tail;
		int unsigned n;
		int          i;
		ranked_t     r;
		lim = cap_limit();
		if (model_fill > lim)
			model_fill = lim;
		pos = 0;
		// equal scores stay ahead of the newcomer
		while (pos < model_fill && model_score[pos] >= s)
			pos++;
		if (pos < lim) begin
			tail = (model_fill < lim) ? model_fill : lim - 1;
			for (i = tail; i > pos; i--) begin
				model_score[i] = model_score[i-1];
				model_x[i]     = model_x[i-1];
				model_y[i]     = model_y[i-1];
			end
			model_score[pos] = s;
			model_x[pos]     = x;
			model_y[pos]     = y;
			if (model_fill < lim)
				model_fill++;
		end
		if (!last)
			return;
		lim = cap_limit();
		if (model_fill > lim)
			model_fill = lim;
		n = model_fill;
		model_fill = 0;
		if (n == 0) begin
			r = '0;
			r.empty   = 1'b1;
			r.run_end = 1'b1;
			ranked_due = {ranked_due, r};
		end else begin
			for (i = 0; i < n; i++) begin
				r.x_bits   = model_x[i];
				r.y_bits   = model_y[i];
				r.strength = model_score[i];
				r.rank     = i[RANK_W-1:0];
				r.count    = n[COUNT_W-1:0];
				r.empty    = 1'b0;
				r.run_end  = (i == n - 1);
				ranked_due = {ranked_due, r};
			end
		end
	endfunction

	function automatic int unsigned idle_pct(input pace_e p, input bit tx);
		case (p)
			PACE_RX_SLOW: return tx ? 31 : 83;
			PACE_TX_SLOW: return tx ? 83 : 31;
			default:      return 0;
		endcase
	endfunction

	// random idling with occasional stretches of none
	function automatic bit take_break(inout int unsigned calm, input int unsigned pct);
		if (calm != 0) begin
			calm--;
			return 1'b0;
		end
		if ($urandom_range(63) == 0)
			calm = $urandom_range(40, 10);
		return $urandom_range(99) < pct;
	endfunction

	// request driver: offers points, applies limit writes and pauses from the queue
	always @(posedge clk) begin
		if (arst_n) begin
			drv_fire = in_valid && in_ready;
			if (drv_fire)
				rank_keypoint(point_x_bits, point_y_bits, strength, frame_end);
			drv_valid = in_valid && !drv_fire;
			drv_wr = 1'b0;
			settle = (!in_valid && ranked_due.size() == 0) ? settle + 1 : 0;
			if (!drv_valid && pending.size() != 0) begin
				drv_head = pending[0];
				case (drv_head.kind)
					STEP_POINT: begin
						if (!take_break(tx_calm, idle_pct(pace, 1'b1))) begin
							point_x_bits <= drv_head.x_bits;
							point_y_bits <= drv_head.y_bits;
							strength     <= drv_head.strength;
							frame_end    <= drv_head.last;
							drv_valid = 1'b1;
							void'(pending.pop_front());
						end
					end
					STEP_PACE: begin
						pace <= drv_head.pace;
						void'(pending.pop_front());
					end
					STEP_DRAIN: begin
						if (settle >= 2)
							void'(pending.pop_front());
					end
					STEP_LIMIT: begin
						// block idle and settled: safe to rewrite the limit
						if (settle >= SETTLE_CYCLES) begin
							drv_wr = 1'b1;
							cfg_wr_data <= drv_head.limit;
							model_limit = drv_head.limit;
							settle = 0;
							void'(pending.pop_front());
						end
					end
					default: void'(pending.pop_front());
				endcase
			end
			in_valid  <= drv_valid;
			cfg_wr_en <= drv_wr;
		end
	end

	// result monitor and back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (ranked_due.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected result: x=%h y=%h s=%h rank=%0d count=%0d empty=%b end=%b",
							out_x_bits, out_y_bits, out_strength, rank, kept_count, empty_res,
							run_end);
				end else begin
					if (ranked_due[0].x_bits !== out_x_bits || ranked_due[0].y_bits !== out_y_bits
							|| ranked_due[0].strength !== out_strength
							|| ranked_due[0].rank !== rank || ranked_due[0].count !== kept_count
							|| ranked_due[0].empty !== empty_res
							|| ranked_due[0].run_end !== run_end) begin
						fails++;
						if (fails <= 10) begin
							$display("mismatch exp: x=%h y=%h s=%h rank=%0d count=%0d empty=%b end=%b",
								ranked_due[0].x_bits, ranked_due[0].y_bits, ranked_due[0].strength,
								ranked_due[0].rank, ranked_due[0].count, ranked_due[0].empty,
								ranked_due[0].run_end);
							$display("         got: x=%h y=%h s=%h rank=%0d count=%0d empty=%b end=%b",
								out_x_bits, out_y_bits, out_strength, rank, kept_count, empty_res,
								run_end);
						end
					end
					void'(ranked_due.pop_front());
				end
			end
			out_ready <= !take_break(rx_calm, idle_pct(pace, 1'b0));
		end
	end

	task automatic add_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [SCORE_W-1:0] s, input logic last);
		step_t st;
		st = '0;
		st.kind     = STEP_POINT;
		st.x_bits   = x;
		st.y_bits   = y;
		st.strength = s;
		st.last     = last;
		pending = {pending, st};
	endtask

	task automatic add_limit(input logic [LIMIT_W-1:0] v);
		step_t st;
		st = '0;
		st.kind  = STEP_LIMIT;
		st.limit = v;
		pending = {pending, st};
	endtask

	task automatic add_pace(input pace_e p);
		step_t st;
		st = '0;
		st.kind = STEP_PACE;
		st.pace = p;
		pending = {pending, st};
	endtask

	task automatic add_drain();
		step_t st;
		st = '0;
		st.kind = STEP_DRAIN;
		pending = {pending, st};
	endtask

	// scores lean towards ties and extremes now and then
	function automatic logic [SCORE_W-1:0] pick_strength();
		case ($urandom_range(7))
			0, 1:    return $urandom_range(3);
			2:       return $urandom_range(1) ? '1 : '0;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_frame(input int len, input bit closed);
		int k;
		for (k = 0; k < len; k++)
			add_point($urandom, $urandom, pick_strength(), closed && (k == len - 1));
	endtask

	// complete frames of mostly short length, optionally leaving one open
	task automatic add_frames(input int items, input bit leave_open);
		int len;
		while (items > 0) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(30, 12) : $urandom_range(8, 1);
			if (len > items)
				len = items;
			add_frame(len, 1'b1);
			items -= len;
		end
		if (leave_open)
			add_frame($urandom_range(4, 1), 1'b0);
	endtask

	initial begin
		// single lowest keypoint at the reset limit
		add_point('0, '0, '0, 1'b1);
		// extreme fields and a tie on the top score
		add_point('1, '1, '1, 1'b0);
		add_point(32'h0000_0001, 32'h8000_0000, '0, 1'b0);
		add_point(32'h7fff_ffff, 32'h0000_0000, '1, 1'b0);
		add_point(32'h5555_5555, 32'haaaa_aaaa, 32'd7, 1'b1);
		// zero limit: nothing kept, empty result
		add_limit(7'd0);
		add_point(32'd1, 32'd2, 32'd3, 1'b0);
		add_point(32'd4, 32'd5, 32'd6, 1'b1);
		add_point(32'd7, 32'd8, 32'd9, 1'b1);
		// limit above the store depth
		add_limit(7'd127);
		add_point(32'h1234_5678, 32'h9abc_def0, 32'd100, 1'b0);
		add_point(32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'd200, 1'b1);
		// full store: late ties and low scores are discarded, the tail falls off
		add_limit(7'd2);
		add_point(32'd10, 32'd11, 32'd5, 1'b0);
		add_point(32'd12, 32'd13, 32'd9, 1'b0);
		add_point(32'd14, 32'd15, 32'd5, 1'b0);
		add_point(32'd16, 32'd17, 32'd9, 1'b0);
		add_point(32'd18, 32'd19, 32'd1, 1'b1);
		// limit lowered while a frame is open
		add_limit(7'd4);
		add_point(32'd20, 32'd21, 32'd40, 1'b0);
		add_point(32'd22, 32'd23, 32'd30, 1'b0);
		add_point(32'd24, 32'd25, 32'd20, 1'b0);
		add_point(32'd26, 32'd27, 32'd10, 1'b0);
		add_limit(7'd1);
		add_point(32'd28, 32'd29, 32'd25, 1'b1);

		// random part: sender slow, receiver slower
		add_limit(7'd5);
		add_frames(30, 1'b1);
		add_limit(7'd64);
		add_frame(68, 1'b1);
		add_frames(10, 1'b0);
		add_limit(7'd1);
		add_frames(10, 1'b0);
		add_drain();
		add_frames(10, 1'b0);
		// receiver fast, sender slow
		add_pace(PACE_TX_SLOW);
		add_limit(7'd127);
		add_frames(30, 1'b1);
		add_limit(7'd0);
		add_frames(12, 1'b0);
		add_limit(LIMIT_W'($urandom_range(127)));
		add_frames(10, 1'b0);
		add_limit(7'd3);
		add_frames(30, 1'b1);
		// no idling on either side
		add_pace(PACE_FREE);
		add_limit(7'd70);
		add_frames(30, 1'b1);
		add_limit(LIMIT_W'($urandom_range(16, 2)));
		add_frames(30, 1'b0);
		add_drain();
		add_frames(10, 1'b0);
		add_limit(7'd64);
		add_frames(20, 1'b0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (pending.size() != 0 || in_valid || ranked_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fails == 0 && ranked_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("tb: failure");
		$finish;
	end

endmodule
